// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the infix to postfix converter
// Operator codes, character constants, precedence and stack control types.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int DEFAULT_STACK_DEPTH = 32;

  typedef logic [2:0] op_code_t;
  typedef logic [1:0] prec_t;
  typedef logic [1:0] status_t;

  // Operator codes as held on the stack
  localparam op_code_t OP_NONE   = 3'd0;
  localparam op_code_t OP_POW    = 3'd1;
  localparam op_code_t OP_MUL    = 3'd2;
  localparam op_code_t OP_DIV    = 3'd3;
  localparam op_code_t OP_ADD    = 3'd4;
  localparam op_code_t OP_SUB    = 3'd5;
  localparam op_code_t OP_LPAREN = 3'd6;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNMATCHED = 2'd2;

  // ASCII characters of interest
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Push and pop command to the chain of stack cells
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stack_ctl_t;

  function automatic op_code_t char_to_op(input logic [7:0] ch);
    op_code_t res;
    unique case (ch)
      CH_POW:  res = OP_POW;
      CH_MUL:  res = OP_MUL;
      CH_DIV:  res = OP_DIV;
      CH_ADD:  res = OP_ADD;
      CH_SUB:  res = OP_SUB;
      default: res = OP_NONE;
    endcase
    return res;
  endfunction

  function automatic prec_t op_prec(input op_code_t code);
    prec_t res;
    unique case (code) inside
      OP_POW:          res = 2'd3;
      OP_MUL, OP_DIV:  res = 2'd2;
      OP_ADD, OP_SUB:  res = 2'd1;
      default:         res = 2'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] res;
    unique case (code)
      OP_POW:    res = CH_POW;
      OP_MUL:    res = CH_MUL;
      OP_DIV:    res = CH_DIV;
      OP_ADD:    res = CH_ADD;
      OP_SUB:    res = CH_SUB;
      OP_LPAREN: res = CH_LPAREN;
      default:   res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/itp_cell.sv
// ----------------------------------------------------------------------------
// itp_cell: one entry of the operator stack
// Loads from the neighbor above on push and from the neighbor below on pop.
// ----------------------------------------------------------------------------
module itp_cell (
  input  logic                clk,
  input  itp_pkg::stack_ctl_t ctl,
  input  itp_pkg::op_code_t   from_up,
  input  itp_pkg::op_code_t   from_down,
  output itp_pkg::op_code_t   q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= from_up;
    end else if (ctl.pop) begin
      q <= from_down;
    end
  end

endmodule

// File: rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack: operator stack built as a chain of shifting cells
// Cell 0 is the top; push shifts every entry down, pop shifts every entry up.
// ----------------------------------------------------------------------------
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                clk,
  input  itp_pkg::stack_ctl_t ctl,
  output itp_pkg::op_code_t   top_code
);

  itp_pkg::op_code_t q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    itp_pkg::op_code_t from_up;
    itp_pkg::op_code_t from_down;

    if (i == 0) begin : g_top
      assign from_up = ctl.code;
    end else begin : g_mid_up
      assign from_up = q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign from_down = q[i];
    end else begin : g_mid_down
      assign from_down = q[i+1];
    end

    itp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (from_up),
      .from_down (from_down),
      .q         (q[i])
    );
  end

  assign top_code = q[0];

endmodule

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Flow: a character is taken only in idle; the sequencer then does its stack steps
//   (pop or push) one at a time, and each result waits in the hold register.
// A new character is not taken until every step of the last one is done; a
//   full output side stalls the steps. The stack sequencer sets the pace.
// Reset: clears sequencer state, stack level and result valid flags; stack
//   cells are not reset and are read only below the stack level.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       expr_end,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_end,
  output logic [1:0] status
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAIN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [LW-1:0] level;

  // Latched character under work
  logic [7:0] ch;
  logic       last;

  // Hold stage: the newest result waits here until we know whether it is
  // the final one for its character, which sets run_end.
  logic             hold_valid;
  logic [7:0]       hold_char;
  itp_pkg::status_t hold_status;

  itp_pkg::stack_ctl_t ctl;
  itp_pkg::op_code_t   top_code;
  itp_pkg::op_code_t   ch_code;

  logic             top_ok;
  logic             full;
  logic             emit;
  logic [7:0]       emit_char;
  itp_pkg::status_t emit_status;
  logic             want_push;
  logic             want_pop;
  itp_pkg::op_code_t push_code;
  logic             done;
  logic             busy;
  logic             advance;
  logic             can_emit;
  logic             in_fire;
  logic             hold_to_out;
  logic             hold_final;

  assign ch_code  = itp_pkg::char_to_op(ch);
  assign top_ok   = (level != '0);
  assign full     = (level == LEVEL_FULL);
  assign can_emit = !out_valid || !out_stall;
  assign busy     = (state == S_MAIN) || (state == S_FLUSH);

  // One stack step of the character under work
  always_comb begin
    emit        = 1'b0;
    emit_char   = 8'h00;
    emit_status = itp_pkg::ST_OK;
    want_push   = 1'b0;
    want_pop    = 1'b0;
    push_code   = ch_code;
    done        = 1'b0;
    unique case (state)
      S_MAIN: begin
        if (ch_code != itp_pkg::OP_NONE) begin
          // pop while the stacked operator binds at least as tightly
          if (top_ok && (itp_pkg::op_prec(top_code) >= itp_pkg::op_prec(ch_code))) begin
            emit      = 1'b1;
            emit_char = itp_pkg::op_char(top_code);
            want_pop  = 1'b1;
          end else if (!full) begin
            want_push = 1'b1;
            done      = 1'b1;
          end else begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_OVERFLOW;
            done        = 1'b1;
          end
        end else if (ch == itp_pkg::CH_LPAREN) begin
          push_code = itp_pkg::OP_LPAREN;
          done      = 1'b1;
          if (!full) begin
            want_push = 1'b1;
          end else begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_OVERFLOW;
          end
        end else if (ch == itp_pkg::CH_RPAREN) begin
          if (top_ok && (top_code != itp_pkg::OP_LPAREN)) begin
            emit      = 1'b1;
            emit_char = itp_pkg::op_char(top_code);
            want_pop  = 1'b1;
          end else if (top_ok) begin
            // drop the matching open parenthesis
            want_pop = 1'b1;
            done     = 1'b1;
          end else begin
            emit        = 1'b1;
            emit_status = itp_pkg::ST_UNMATCHED;
            done        = 1'b1;
          end
        end else if (ch == itp_pkg::CH_SPACE) begin
          done = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_char = ch;
          done      = 1'b1;
        end
      end
      S_FLUSH: begin
        if (top_ok) begin
          // an unmatched open parenthesis leaves silently
          want_pop  = 1'b1;
          emit      = (top_code != itp_pkg::OP_LPAREN);
          emit_char = itp_pkg::op_char(top_code);
        end else begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the step while a new result would overrun a full output side
  assign advance = busy && !(emit && hold_valid && !can_emit);

  assign ctl.push = advance && want_push;
  assign ctl.pop  = advance && want_pop;
  assign ctl.code = push_code;

  itp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .ctl      (ctl),
    .top_code (top_code)
  );

  // In idle the pending result of the previous character is final
  assign in_stall    = (state != S_IDLE) || (hold_valid && !can_emit);
  assign in_fire     = in_valid && !in_stall;
  assign hold_final  = (state == S_IDLE) && hold_valid && can_emit;
  assign hold_to_out = hold_final || (advance && emit && hold_valid);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (advance && done) begin
          state_next = last ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (advance && done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      level      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (ctl.push) begin
        level <= level + LW'(1);
      end else if (ctl.pop) begin
        level <= level - LW'(1);
      end

      if (advance && emit) begin
        hold_valid <= 1'b1;
      end else if (hold_final) begin
        hold_valid <= 1'b0;
      end

      if (hold_to_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch   <= in_char;
      last <= expr_end;
    end
    if (advance && emit) begin
      hold_char   <= emit_char;
      hold_status <= emit_status;
    end
    if (hold_to_out) begin
      out_char <= hold_char;
      status   <= hold_status;
      run_end  <= hold_final;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_FULL)
    else $error("stack level beyond depth");

  a_push_not_full : assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !full)
    else $error("push into a full stack");

  a_accept_idle : assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (state == S_IDLE))
    else $error("character taken while busy");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != itp_pkg::ST_OK)) |-> (out_char == 8'h00))
    else $error("error result carries a character");

endmodule

// File: tb/sv/infix_to_postfix_converter_test.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test: self-checking bench for the converter
// Feeds infix text one character per transaction and checks every postfix
// result against an in-bench shunting-yard predictor. The run covers directed
// cases, stack overflow and unmatched parentheses, a long output hold-off,
// and random expressions mixed with broken sequences and raw noise bytes.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_test;

  localparam int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH;
  localparam int HOLD_CYCLES = 300;  // long output hold-off
  localparam int TAIL_CYCLES = 80;   // settle time after the last result
  localparam int RANDOM_ITEMS = 140;
  localparam int PHASE_ITEMS = 24;   // characters between idle level changes

  // One postfix result as the block presents it
  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    itp_pkg::status_t st;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       expr_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       run_end;
  logic [1:0] status;

  // Predictor state: operator stack and its fill level
  itp_pkg::op_code_t opstk [STACK_DEPTH];
  int                stk_level = 0;
  postfix_t          postfix_q [$];   // postfix results still owed by the block

  // Idle control, changed from test to test
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Run statistics
  int errors = 0;
  int n_chars = 0;
  int n_checked = 0;
  int n_overflow = 0;
  int n_unmatched = 0;
  int n_sent = 0;

  logic [7:0] expr_buf [$];    // text of the expression being built

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .expr_end (expr_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .run_end  (run_end),
    .status   (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends up here
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shunting-yard predictor
  // --------------------------------------------------------------------------

  // Map a character to its stack code; anything else is not an operator
  function automatic itp_pkg::op_code_t code_of(input logic [7:0] c);
    if (c == itp_pkg::CH_POW) return itp_pkg::OP_POW;
    if (c == itp_pkg::CH_MUL) return itp_pkg::OP_MUL;
    if (c == itp_pkg::CH_DIV) return itp_pkg::OP_DIV;
    if (c == itp_pkg::CH_ADD) return itp_pkg::OP_ADD;
    if (c == itp_pkg::CH_SUB) return itp_pkg::OP_SUB;
    return itp_pkg::OP_NONE;
  endfunction

  // Binding strength on the stack; a stacked '(' ranks lowest and stops pops
  function automatic int rank(input itp_pkg::op_code_t k);
    if (k == itp_pkg::OP_POW) return 3;
    if (k == itp_pkg::OP_MUL || k == itp_pkg::OP_DIV) return 2;
    if (k == itp_pkg::OP_ADD || k == itp_pkg::OP_SUB) return 1;
    return 0;
  endfunction

  function automatic logic [7:0] glyph(input itp_pkg::op_code_t k);
    if (k == itp_pkg::OP_POW) return itp_pkg::CH_POW;
    if (k == itp_pkg::OP_MUL) return itp_pkg::CH_MUL;
    if (k == itp_pkg::OP_DIV) return itp_pkg::CH_DIV;
    if (k == itp_pkg::OP_ADD) return itp_pkg::CH_ADD;
    if (k == itp_pkg::OP_SUB) return itp_pkg::CH_SUB;
    return 8'h00;
  endfunction

  // Work out every result one accepted character causes and queue them
  function automatic void shunt_char(input logic [7:0] c, input logic last);
    itp_pkg::op_code_t k;
    itp_pkg::op_code_t push_code;
    postfix_t res [$];
    k = code_of(c);
    push_code = itp_pkg::OP_NONE;
    if (k != itp_pkg::OP_NONE) begin
      // pop everything that binds at least as tightly, then push
      while (stk_level > 0 && rank(opstk[stk_level-1]) >= rank(k)) begin
        res.push_back(postfix_t'{glyph(opstk[stk_level-1]), 1'b0, itp_pkg::ST_OK});
        stk_level--;
      end
      push_code = k;
    end else if (c == itp_pkg::CH_LPAREN) begin
      push_code = itp_pkg::OP_LPAREN;
    end else if (c == itp_pkg::CH_RPAREN) begin
      while (stk_level > 0 && opstk[stk_level-1] != itp_pkg::OP_LPAREN) begin
        res.push_back(postfix_t'{glyph(opstk[stk_level-1]), 1'b0, itp_pkg::ST_OK});
        stk_level--;
      end
      if (stk_level > 0) begin
        stk_level--;
      end else begin
        res.push_back(postfix_t'{8'h00, 1'b0, itp_pkg::ST_UNMATCHED});
        n_unmatched++;
      end
    end else if (c != itp_pkg::CH_SPACE) begin
      res.push_back(postfix_t'{c, 1'b0, itp_pkg::ST_OK});
    end

    if (push_code != itp_pkg::OP_NONE) begin
      if (stk_level < STACK_DEPTH) begin
        opstk[stk_level] = push_code;
        stk_level++;
      end else begin
        // full stack: drop the operator and flag it
        res.push_back(postfix_t'{8'h00, 1'b0, itp_pkg::ST_OVERFLOW});
        n_overflow++;
      end
    end

    if (last) begin
      // flush; a leftover '(' goes away without a result
      while (stk_level > 0) begin
        if (opstk[stk_level-1] != itp_pkg::OP_LPAREN)
          res.push_back(postfix_t'{glyph(opstk[stk_level-1]), 1'b0, itp_pkg::ST_OK});
        stk_level--;
      end
    end

    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) postfix_q.push_back(res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------

  // Predict at the edge where the input transaction completes
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      shunt_char(in_char, expr_end);
      n_chars++;
    end
  end

  // Compare each output transaction against the oldest owed result
  always @(posedge clk) begin
    postfix_t want;
    if (!rst && out_valid && !out_stall) begin
      if (postfix_q.size() == 0) begin
        $display("%0t: expected no result, actual char=%h run_end=%b status=%0d",
                 $time, out_char, run_end, status);
        errors++;
      end else begin
        want = postfix_q.pop_front();
        n_checked++;
        if (out_char !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          errors++;
        end
        if (run_end !== want.last) begin
          $display("%0t: run_end expected %b actual %b", $time, want.last, run_end);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle generation
  // --------------------------------------------------------------------------

  // Gap length from three bands: mostly the shortest, sometimes the middle, rarely the longest
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 93) return $urandom_range(6, 3);
    return $urandom_range(40, 10);
  endfunction

  // Receiver: a requested long hold-off wins, else random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99, 0) < recv_stall_pct) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one character, possibly after a gap, and hold until it is taken
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if ($urandom_range(99, 0) < send_idle_pct) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_char  <= 8'($urandom_range(255, 0));
      expr_end <= 1'($urandom_range(1, 0));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    expr_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c != itp_pkg::CH_SPACE) n_sent++;
  endtask

  // Send a text literal, marking its final character as the end
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Send the built expression, marking its final character as the end
  task automatic send_buf();
    for (int i = 0; i < expr_buf.size(); i++)
      send_char(expr_buf[i], i == expr_buf.size() - 1);
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(4, 0))
      0:       return itp_pkg::CH_POW;
      1:       return itp_pkg::CH_MUL;
      2:       return itp_pkg::CH_DIV;
      3:       return itp_pkg::CH_ADD;
      default: return itp_pkg::CH_SUB;
    endcase
  endfunction

  // Any byte that is neither operator, parenthesis nor space
  function automatic logic [7:0] operand_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255, 0));
    end while (code_of(c) != itp_pkg::OP_NONE || c == itp_pkg::CH_LPAREN ||
               c == itp_pkg::CH_RPAREN || c == itp_pkg::CH_SPACE);
    return c;
  endfunction

  // Append a well-formed expression with random operands, operators,
  // spacing and nested parentheses
  task automatic build_expr(input int nest);
    int terms;
    terms = $urandom_range(4, 1);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        if ($urandom_range(4, 0) == 0) expr_buf.push_back(itp_pkg::CH_SPACE);
        expr_buf.push_back(pick_op());
        if ($urandom_range(4, 0) == 0) expr_buf.push_back(itp_pkg::CH_SPACE);
      end
      if (nest > 0 && $urandom_range(3, 0) == 0) begin
        expr_buf.push_back(itp_pkg::CH_LPAREN);
        build_expr(nest - 1);
        expr_buf.push_back(itp_pkg::CH_RPAREN);
      end else begin
        expr_buf.push_back(operand_char());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Byte extremes, every operator, grouping, associativity, unmatched
  // parentheses both ways, and the end mark on an operator and on a space
  task automatic test_directed();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("a^b^c");
    send_text("(x+y)/z-w*v");
    send_text("p-)");
    send_text("((q");
    send_text("s+");
    send_text("r* ");
    wait_drained();
  endtask

  // Fill the stack: overflow on '(' and on an operator, then a lone ')'
  task automatic test_overflow();
    send_idle_pct  = 0;
    recv_stall_pct = 10;
    repeat (STACK_DEPTH + 1) send_char(itp_pkg::CH_LPAREN, 1'b0);
    send_char("k", 1'b1);
    repeat (STACK_DEPTH - 1) send_char(itp_pkg::CH_LPAREN, 1'b0);
    send_text("a*b+c-");
    send_char(itp_pkg::CH_POW, 1'b0);
    send_char("d", 1'b1);
    // deep flush: sixteen operators under sixteen parentheses
    repeat (STACK_DEPTH / 2) begin
      send_char(operand_char(), 1'b0);
      send_char(pick_op(), 1'b0);
      send_char(itp_pkg::CH_LPAREN, 1'b0);
    end
    send_char(operand_char(), 1'b1);
    send_char(itp_pkg::CH_RPAREN, 1'b1);
    wait_drained();
  endtask

  // Hold the output for a long stretch while input keeps coming, so the
  // block backs up into its input stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    repeat (60) send_char(operand_char(), 1'b0);
    send_text("(a+b)*c^d-e/f");
    wait_drained();
  endtask

  // Mostly well-formed expressions; some broken ones, some raw noise and
  // some deep unclosed nests; idle levels change every 24 characters
  task automatic test_random();
    int start;
    int phase;
    int r;
    int pos;
    start = n_sent;
    phase = -1;
    while (n_sent - start < RANDOM_ITEMS) begin
      if ((n_sent - start) / PHASE_ITEMS != phase) begin
        phase = (n_sent - start) / PHASE_ITEMS;
        case (phase % 6)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 25; recv_stall_pct = 25; end
          2: begin send_idle_pct = 60; recv_stall_pct = 10; end
          3: begin send_idle_pct = 10; recv_stall_pct = 60; end
          4: begin send_idle_pct = 40; recv_stall_pct = 40; end
          default: begin send_idle_pct = 0; recv_stall_pct = 50; end
        endcase
      end
      r = $urandom_range(99, 0);
      expr_buf.delete();
      if (r < 68) begin
        build_expr($urandom_range(3, 0));
        send_buf();
      end else if (r < 83) begin
        // break a good expression: lose a character or add a parenthesis
        build_expr($urandom_range(2, 0));
        pos = $urandom_range(expr_buf.size() - 1, 0);
        case ($urandom_range(2, 0))
          0:       expr_buf.delete(pos);
          1:       expr_buf.insert(pos, itp_pkg::CH_RPAREN);
          default: expr_buf.insert(pos, itp_pkg::CH_LPAREN);
        endcase
        send_buf();
      end else if (r < 95) begin
        repeat ($urandom_range(8, 1))
          send_char(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0);
      end else begin
        repeat ($urandom_range(20, 1)) begin
          expr_buf.push_back(operand_char());
          expr_buf.push_back(pick_op());
          expr_buf.push_back(itp_pkg::CH_LPAREN);
        end
        expr_buf.push_back(operand_char());
        send_buf();
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d characters into %0d checked postfix results.",
             n_chars, n_checked);
    $display("Flags seen: %0d stack overflow, %0d unmatched close parenthesis.",
             n_overflow, n_unmatched);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
